>>> hdl/dgvb_pkg.sv
// Shared types, constants and rounding helper for the vertex blend core.
// No dependencies; imported by dgvb_mul, the top level and the bench.
package dgvb_pkg;

  localparam int WORDS_PER_NODE = 12;

  // command codes of an input word
  localparam logic CMD_LOAD      = 1'b0;  // store one transform word
  localparam logic CMD_NEIGHBOUR = 1'b1;  // one neighbour of a vertex

  typedef logic signed [31:0] word_t;   // Q16.16 word
  typedef logic signed [55:0] acc_t;    // Q24.32 blend sum
  typedef logic signed [63:0] prod_t;   // full product
  typedef logic signed [65:0] dsum_t;   // sum of three products

  // Q24.32 -> Q16.16: floor((a + 2^15) / 2^16), saturated to 32 bits
  function automatic word_t acc_round(input acc_t a);
    logic signed [56:0] s;
    logic signed [40:0] q;
    word_t res;
    s = {a[55], a} + 57'sd32768;
    q = s[56:16];
    if (q[40:31] == {10{q[40]}}) begin
      res = q[31:0];
    end else begin
      res = q[40] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return res;
  endfunction

endpackage

>>> hdl/dgvb_mul.sv
// Shared signed 32x32 multiplier with registered product.
// Depends on dgvb_pkg.
module dgvb_mul (
  input  logic           clk,
  input  logic           en,
  input  dgvb_pkg::word_t a,
  input  dgvb_pkg::word_t b,
  output dgvb_pkg::prod_t p
);
  import dgvb_pkg::*;

  prod_t p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= prod_t'(a) * prod_t'(b);
    end
  end

  assign p = p_r;

endmodule

>>> hdl/deformation_graph_vertex_blend_core.sv
// Deformation-graph vertex blend core: transform store, blend accumulator, sequencer.
// Depends on dgvb_pkg and dgvb_mul.
//
// Usage
//   Input channel (in_*): one word per item. command 0 writes one transform
//   word (node, element 0..11) into the store; out-of-range loads are dropped.
//   command 1 is one neighbour of a vertex: weight times the node's 3x4
//   transform is added into the accumulator (node -1 or out of range adds
//   nothing). A neighbour with last_neighbor set also closes the vertex: the
//   blended transform is applied to pos (w = 1) and its 3x3 part to nrm, one
//   result word goes out and the accumulator clears.
//   Result channel (out_*): one word per closed vertex, saturated Q16.16.
//   Steps: a load leaves the sequencer idle. A neighbour in range reads,
//   multiplies and accumulates each of its 12 words on the one shared
//   multiplier. Closing forms 18 products, 3 for each of the 6 outputs, rounds
//   each output, adds the translation to positions and hands over to the output register.
//   in_stall is high whenever the sequencer is busy.
//   The result sits in its own output register, so the next item is taken
//   while the receiver stalls; only a second result waits for the first to go.
//   Reset (synchronous, rst_n low) clears the sequencer, the accumulator and
//   out_valid. The transform store is not cleared: read only written words.
module deformation_graph_vertex_blend_core #(
  parameter int NODE_COUNT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic signed [10:0]   in_node_index,
  input  logic [3:0]           in_element_index,
  input  dgvb_pkg::word_t      in_element_value,
  input  logic [16:0]          in_blend_weight,
  input  logic                 in_last_neighbor,
  input  dgvb_pkg::word_t      in_pos_x,
  input  dgvb_pkg::word_t      in_pos_y,
  input  dgvb_pkg::word_t      in_pos_z,
  input  dgvb_pkg::word_t      in_nrm_x,
  input  dgvb_pkg::word_t      in_nrm_y,
  input  dgvb_pkg::word_t      in_nrm_z,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output dgvb_pkg::word_t      out_pos_x,
  output dgvb_pkg::word_t      out_pos_y,
  output dgvb_pkg::word_t      out_pos_z,
  output dgvb_pkg::word_t      out_nrm_x,
  output dgvb_pkg::word_t      out_nrm_y,
  output dgvb_pkg::word_t      out_nrm_z
);
  import dgvb_pkg::*;

  localparam int StoreDepth = NODE_COUNT * WORDS_PER_NODE;
  localparam int AddrW      = $clog2(StoreDepth);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_B_RD  = 4'd1;  // issue store read
  localparam logic [3:0] S_B_MUL = 4'd2;  // word x weight
  localparam logic [3:0] S_B_ACC = 4'd3;  // saturating add into acc
  localparam logic [3:0] S_F_OP  = 4'd4;  // round acc entry, pick vector comp
  localparam logic [3:0] S_F_MUL = 4'd5;
  localparam logic [3:0] S_F_ACC = 4'd6;  // dot-product sum
  localparam logic [3:0] S_F_RND = 4'd7;  // round sum, fetch translation
  localparam logic [3:0] S_F_OUT = 4'd8;  // add translation, saturate
  localparam logic [3:0] S_F_DONE = 4'd9; // hand over to output register

  logic [3:0]       state_r, state_nxt;
  logic [3:0]       k_r, k_nxt;        // word within transform (blend)
  logic [1:0]       r_r, r_nxt;        // output row
  logic [1:0]       j_r, j_nxt;        // column within dot product
  logic             vsel_r, vsel_nxt;  // 0 position, 1 normal
  logic             in_acc;
  logic             node_ok;
  logic [31:0]      node_base;
  logic [AddrW-1:0] base_r;
  logic [AddrW-1:0] rd_addr;
  logic [16:0]      weight_r;
  logic             last_r;

  word_t store [StoreDepth];
  word_t rd_data_r;
  acc_t  acc_r [WORDS_PER_NODE];
  word_t pos_r [3];
  word_t nrm_r [3];
  word_t opa_r, opb_r;
  dsum_t dsum_r;
  logic signed [49:0] rnd_r;
  word_t res_pos_r [3];
  word_t res_nrm_r [3];

  logic  out_valid_r;
  word_t out_pos_x_r, out_pos_y_r, out_pos_z_r;
  word_t out_nrm_x_r, out_nrm_y_r, out_nrm_z_r;

  logic  mul_en;
  word_t mul_a, mul_b;
  prod_t prod;

  logic signed [56:0] acc_sum;
  dsum_t              rnd_sum;
  logic signed [50:0] fin_sum;
  word_t              fin_sat;
  logic               out_load;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign node_ok  = !in_node_index[10]
                    && ({22'd0, in_node_index[9:0]} < 32'(NODE_COUNT));
  assign node_base = {22'd0, in_node_index[9:0]} * 32'd12;
  assign rd_addr   = base_r + AddrW'(k_r);

  // transform store: written on load words, read one word per blend step
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_LOAD && node_ok
        && in_element_index < 4'(WORDS_PER_NODE)) begin
      store[AddrW'(node_base + {28'd0, in_element_index})] <= in_element_value;
    end
    rd_data_r <= store[rd_addr];
  end

  // shared multiplier
  assign mul_en = (state_r == S_B_MUL) || (state_r == S_F_MUL);
  assign mul_a  = (state_r == S_B_MUL) ? rd_data_r : opa_r;
  assign mul_b  = (state_r == S_B_MUL) ? word_t'({15'd0, weight_r}) : opb_r;

  dgvb_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // blend add: product fits 49 bits, so 57 bits catch any overflow
  assign acc_sum = {acc_r[k_r][55], acc_r[k_r]} + prod[56:0];
  assign rnd_sum = dsum_r + 66'sd32768;
  assign fin_sum = {rnd_r[49], rnd_r} + {{19{opa_r[31]}}, opa_r};
  always_comb begin
    if (fin_sum[50:31] == {20{fin_sum[50]}}) begin
      fin_sat = fin_sum[31:0];
    end else begin
      fin_sat = fin_sum[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign out_load = (state_r == S_F_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    j_nxt     = j_r;
    vsel_nxt  = vsel_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt    = '0;
        r_nxt    = '0;
        j_nxt    = '0;
        vsel_nxt = 1'b0;
        if (in_acc && in_command != CMD_LOAD) begin
          if (node_ok) begin
            state_nxt = S_B_RD;
          end else if (in_last_neighbor) begin
            state_nxt = S_F_OP;
          end
        end
      end
      S_B_RD:  state_nxt = S_B_MUL;
      S_B_MUL: state_nxt = S_B_ACC;
      S_B_ACC: begin
        if (k_r == 4'(WORDS_PER_NODE - 1)) begin
          k_nxt     = '0;
          state_nxt = last_r ? S_F_OP : S_IDLE;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_B_RD;
        end
      end
      S_F_OP:  state_nxt = S_F_MUL;
      S_F_MUL: state_nxt = S_F_ACC;
      S_F_ACC: begin
        if (j_r == 2'd2) begin
          j_nxt     = '0;
          state_nxt = S_F_RND;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_F_OP;
        end
      end
      S_F_RND: state_nxt = S_F_OUT;
      S_F_OUT: begin
        vsel_nxt = !vsel_r;
        if (vsel_r) begin
          if (r_r == 2'd2) begin
            state_nxt = S_F_DONE;
          end else begin
            r_nxt     = r_r + 2'd1;
            state_nxt = S_F_OP;
          end
        end else begin
          state_nxt = S_F_OP;
        end
      end
      S_F_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      r_r     <= '0;
      j_r     <= '0;
      vsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      r_r     <= r_nxt;
      j_r     <= j_nxt;
      vsel_r  <= vsel_nxt;
    end
  end

  // blend accumulator: saturating to 56 bits, cleared when a vertex closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORDS_PER_NODE; i++) begin
        acc_r[i] <= '0;
      end
    end else if (out_load) begin
      for (int i = 0; i < WORDS_PER_NODE; i++) begin
        acc_r[i] <= '0;
      end
    end else if (state_r == S_B_ACC) begin
      if (acc_sum[56] != acc_sum[55]) begin
        acc_r[k_r] <= acc_sum[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
      end else begin
        acc_r[k_r] <= acc_sum[55:0];
      end
    end
  end

  // item latch and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r   <= AddrW'(node_base);
      weight_r <= in_blend_weight;
      last_r   <= in_last_neighbor;
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      nrm_r[0] <= in_nrm_x;
      nrm_r[1] <= in_nrm_y;
      nrm_r[2] <= in_nrm_z;
    end
    case (state_r)
      S_F_OP: begin
        opa_r <= acc_round(acc_r[{r_r, j_r}]);
        opb_r <= vsel_r ? nrm_r[j_r] : pos_r[j_r];
        if (j_r == 2'd0) begin
          dsum_r <= '0;
        end
      end
      S_F_ACC: dsum_r <= dsum_r + {{2{prod[63]}}, prod};
      S_F_RND: begin
        rnd_r <= rnd_sum[65:16];
        // translation column joins the position only
        opa_r <= vsel_r ? '0 : acc_round(acc_r[{r_r, 2'd3}]);
      end
      S_F_OUT: begin
        if (vsel_r) begin
          res_nrm_r[r_r] <= fin_sat;
        end else begin
          res_pos_r[r_r] <= fin_sat;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_x_r <= res_pos_r[0];
      out_pos_y_r <= res_pos_r[1];
      out_pos_z_r <= res_pos_r[2];
      out_nrm_x_r <= res_nrm_r[0];
      out_nrm_y_r <= res_nrm_r[1];
      out_nrm_z_r <= res_nrm_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_pos_z = out_pos_z_r;
  assign out_nrm_x = out_nrm_x_r;
  assign out_nrm_y = out_nrm_y_r;
  assign out_nrm_z = out_nrm_z_r;

endmodule

>>> dv/tb_deformation_graph_vertex_blend_core.sv
`timescale 1ns / 1ps
// Self-checking bench for deformation_graph_vertex_blend_core: directed and random words,
// an in-bench blend predictor and an in-order check of every moved vertex.
// Depends on dgvb_pkg (types and command codes) and the core RTL.
module tb_deformation_graph_vertex_blend_core;
  import dgvb_pkg::*;

  localparam int NODES        = 1024;
  localparam int XFORM_WORDS  = 12;
  localparam int ITEM_TARGET  = 1200;
  // Slowest legal word is a closing neighbour, after the longest send gap and behind the
  // longest receive stall, plus the long pile-up vertex; the limit is the worst case for
  // the whole run, taken four times over.
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int DRAIN_CYCLES = 200;

  localparam int   NO_NODE       = -1;

  // position modes for the rest vertex of a closing word
  localparam int POS_TAME    = 0;
  localparam int POS_WILD    = 1;
  localparam int POS_EXTREME = 2;

  typedef logic signed [79:0] wide_t;

  localparam wide_t W32_MAX = 80'sh7fff_ffff;
  localparam wide_t W32_MIN = -80'sh8000_0000;
  localparam wide_t ACC_MAX = 80'sh7f_ffff_ffff_ffff;
  localparam wide_t ACC_MIN = -80'sh80_0000_0000_0000;
  localparam wide_t HALF_LSB = 80'sd32768;

  typedef struct {
    logic              cmd;
    logic signed [10:0] node;
    logic [3:0]        elem;
    word_t             value;
    logic [16:0]       weight;
    logic              last;
    word_t             px, py, pz, nx, ny, nz;
  } blend_word_t;

  typedef struct {
    word_t px, py, pz, nx, ny, nz;
  } moved_vertex_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = 1'b0;
  logic signed [10:0] in_node_index = '0;
  logic [3:0]         in_element_index = '0;
  word_t              in_element_value = '0;
  logic [16:0]        in_blend_weight = '0;
  logic               in_last_neighbor = 1'b0;
  word_t              in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  word_t              in_nrm_x = '0, in_nrm_y = '0, in_nrm_z = '0;

  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_pos_x, out_pos_y, out_pos_z;
  word_t out_nrm_x, out_nrm_y, out_nrm_z;

  deformation_graph_vertex_blend_core #(
    .NODE_COUNT(NODES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_node_index   (in_node_index),
    .in_element_index(in_element_index),
    .in_element_value(in_element_value),
    .in_blend_weight (in_blend_weight),
    .in_last_neighbor(in_last_neighbor),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_nrm_x        (in_nrm_x),
    .in_nrm_y        (in_nrm_y),
    .in_nrm_z        (in_nrm_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_nrm_x       (out_nrm_x),
    .out_nrm_y       (out_nrm_y),
    .out_nrm_z       (out_nrm_z)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Blend predictor: own copy of the node transforms and of the Q24.32 blend sum.
  // ---------------------------------------------------------------------------
  word_t         node_xform [NODES*XFORM_WORDS];
  acc_t          blend_sum [XFORM_WORDS];
  moved_vertex_t moved_due [$];

  function automatic word_t clip32(wide_t x);
    if (x > W32_MAX) return word_t'(W32_MAX);
    if (x < W32_MIN) return word_t'(W32_MIN);
    return word_t'(x);
  endfunction

  // floor((a.v + 2^15) / 2^16) + offset, exact, then clipped to 32 bits
  function automatic word_t row_apply(word_t a0, word_t a1, word_t a2,
                                      word_t v0, word_t v1, word_t v2, word_t offset);
    wide_t dot;
    dot = wide_t'(a0) * wide_t'(v0) + wide_t'(a1) * wide_t'(v1) + wide_t'(a2) * wide_t'(v2);
    return clip32(((dot + HALF_LSB) >>> 16) + wide_t'(offset));
  endfunction

  function automatic void blend_apply(blend_word_t w);
    int            base;
    int            k;
    wide_t         s;
    word_t         t [XFORM_WORDS];
    moved_vertex_t mv;
    if (w.cmd == CMD_LOAD) begin
      // out-of-range loads are simply dropped, last mark ignored
      if (w.node >= 0 && w.node < NODES && w.elem < XFORM_WORDS)
        node_xform[int'(w.node) * XFORM_WORDS + int'(w.elem)] = w.value;
      return;
    end
    if (w.node >= 0 && w.node < NODES) begin
      base = int'(w.node) * XFORM_WORDS;
      for (k = 0; k < XFORM_WORDS; k++) begin
        s = wide_t'(blend_sum[k]) + wide_t'(w.weight) * wide_t'(node_xform[base + k]);
        if (s > ACC_MAX) s = ACC_MAX;
        if (s < ACC_MIN) s = ACC_MIN;
        blend_sum[k] = acc_t'(s);
      end
    end
    // a neighbour outside the graph adds nothing but may still close the vertex
    if (!w.last) return;
    for (k = 0; k < XFORM_WORDS; k++)
      t[k] = clip32((wide_t'(blend_sum[k]) + HALF_LSB) >>> 16);
    mv.px = row_apply(t[0], t[1], t[2],  w.px, w.py, w.pz, t[3]);
    mv.py = row_apply(t[4], t[5], t[6],  w.px, w.py, w.pz, t[7]);
    mv.pz = row_apply(t[8], t[9], t[10], w.px, w.py, w.pz, t[11]);
    mv.nx = row_apply(t[0], t[1], t[2],  w.nx, w.ny, w.nz, '0);
    mv.ny = row_apply(t[4], t[5], t[6],  w.nx, w.ny, w.nz, '0);
    mv.nz = row_apply(t[8], t[9], t[10], w.nx, w.ny, w.nz, '0);
    moved_due.push_back(mv);
    for (k = 0; k < XFORM_WORDS; k++)
      blend_sum[k] = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus build. Only fully loaded nodes are ever blended, so no neighbour
  // reads a transform word that was never written.
  // ---------------------------------------------------------------------------
  blend_word_t pending [$];
  bit [11:0]   load_mask [NODES];
  bit          node_ready [NODES];
  int          ready_nodes [$];
  int          useful_words;
  int          loads_queued, neighbours_queued, vertices_queued;

  function automatic word_t extreme_word(int sel);
    case (sel % 5)
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return 32'sh0000_0001;
    endcase
  endfunction

  function automatic word_t spread(int unsigned half);
    int unsigned r;
    r = $urandom_range(0, 2 * half);
    return word_t'(r) - word_t'(half);
  endfunction

  function automatic word_t pick_coord(int mode);
    if (mode == POS_EXTREME) return extreme_word($urandom_range(0, 4));
    if (mode == POS_WILD) return word_t'($urandom);
    return spread(32'h40_0000);   // +-64.0
  endfunction

  // rotation/scale words near +-2.0, translations near +-256.0, now and then anything
  function automatic word_t pick_xform_word(int elem);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return extreme_word($urandom_range(0, 4));
    if (r < 3) return word_t'($urandom);
    if (elem % 4 == 3) return spread(32'h100_0000);
    return spread(32'h2_0000);
  endfunction

  function automatic logic [16:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 17'($urandom_range(0, 65536));
    if (r < 9) return 17'($urandom_range(65537, 131071));
    case ($urandom_range(0, 2))
      0:       return 17'd0;
      1:       return 17'd65536;
      default: return 17'd131071;
    endcase
  endfunction

  // every field filled, so ignored fields still toggle
  function automatic blend_word_t noise_word();
    blend_word_t w;
    w.cmd    = 1'($urandom);
    w.node   = 11'($urandom);
    w.elem   = 4'($urandom);
    w.value  = word_t'($urandom);
    w.weight = 17'($urandom);
    w.last   = 1'($urandom);
    w.px = word_t'($urandom);
    w.py = word_t'($urandom);
    w.pz = word_t'($urandom);
    w.nx = word_t'($urandom);
    w.ny = word_t'($urandom);
    w.nz = word_t'($urandom);
    return w;
  endfunction

  function automatic void queue_load(int node, int elem, word_t value, logic last);
    blend_word_t w;
    w       = noise_word();
    w.cmd   = CMD_LOAD;
    w.node  = node[10:0];
    w.elem  = elem[3:0];
    w.value = value;
    w.last  = last;
    pending.push_back(w);
    if (node >= 0 && node < NODES && elem < XFORM_WORDS) begin
      useful_words++;
      loads_queued++;
      load_mask[node][elem] = 1'b1;
      if (load_mask[node] == 12'hfff && !node_ready[node]) begin
        node_ready[node] = 1'b1;
        ready_nodes.push_back(node);
      end
    end
  endfunction

  function automatic void queue_neighbour(int node, logic [16:0] weight, logic last, int mode);
    blend_word_t w;
    w        = noise_word();
    w.cmd    = CMD_NEIGHBOUR;
    w.node   = node[10:0];
    w.weight = weight;
    w.last   = last;
    if (last) begin
      w.px = pick_coord(mode);
      w.py = pick_coord(mode);
      w.pz = pick_coord(mode);
      w.nx = pick_coord(mode);
      w.ny = pick_coord(mode);
      w.nz = pick_coord(mode);
      vertices_queued++;
    end
    pending.push_back(w);
    useful_words++;
    neighbours_queued++;
  endfunction

  function automatic void queue_whole_node(int node);
    int k;
    for (k = 0; k < XFORM_WORDS; k++)
      queue_load(node, k, pick_xform_word(k), 1'($urandom));
  endfunction

  function automatic int pick_graph_node();
    return ready_nodes[$urandom_range(0, ready_nodes.size() - 1)];
  endfunction

  function automatic int pick_stray_node();
    if ($urandom_range(0, 1) == 0) return NO_NODE;
    return -2 - int'($urandom_range(0, 1022));
  endfunction

  function automatic void queue_vertex();
    int n;
    int i;
    int node;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      node = ($urandom_range(0, 99) < 85) ? pick_graph_node() : pick_stray_node();
      queue_neighbour(node, pick_weight(), i == n - 1,
                      ($urandom_range(0, 4) == 0) ? POS_WILD : POS_TAME);
    end
  endfunction

  function automatic void build_stimulus();
    int k;
    int r;
    // node 0 gets extreme words; one of its loads carries a stray last mark
    for (k = 0; k < XFORM_WORDS; k++)
      queue_load(0, k, extreme_word(k), k == 5);
    // loads that must be dropped: negative node, most negative node, bad element
    queue_load(NO_NODE, 0, 32'sh1234_5678, 1'b0);
    queue_load(-1024, 3, 32'sh7fff_ffff, 1'b1);
    queue_load(5, 12, 32'sh8000_0000, 1'b0);
    queue_load(5, 15, 32'sh7fff_ffff, 1'b0);
    // top node index, only partly loaded here, so not blended until fully loaded
    queue_load(NODES - 1, 11, 32'sh8000_0000, 1'b0);
    // empty blend: only a missing neighbour, result must be all zero
    queue_neighbour(NO_NODE, 17'd65536, 1'b1, POS_EXTREME);
    // zero weight
    queue_neighbour(0, 17'd0, 1'b1, POS_EXTREME);
    // weight above one, repeated, onto extreme words: output clipping
    queue_neighbour(0, 17'd131071, 1'b0, POS_TAME);
    queue_neighbour(0, 17'd131071, 1'b0, POS_TAME);
    queue_neighbour(0, 17'd131071, 1'b1, POS_EXTREME);
    // most negative node closes the vertex without adding anything
    queue_neighbour(-1024, 17'd65536, 1'b1, POS_WILD);
    queue_neighbour(0, 17'd65536, 1'b0, POS_TAME);
    queue_neighbour(NO_NODE, 17'd100, 1'b1, POS_TAME);

    // pile-up on the extreme node, enough full-weight adds to pin the blend sum
    for (k = 0; k < 140; k++)
      queue_neighbour(0, 17'd131071, k == 139, POS_WILD);

    while (useful_words < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (ready_nodes.size() < 4 || r < 12) begin
        queue_whole_node($urandom_range(0, NODES - 1));
      end else if (r < 80) begin
        queue_vertex();
      end else if (r < 90) begin
        // single word, may overwrite a live node or fill in a partial one
        queue_load($urandom_range(0, NODES - 1), $urandom_range(0, XFORM_WORDS - 1),
                   pick_xform_word($urandom_range(0, 3)), 1'($urandom));
      end else if (r < 95) begin
        if ($urandom_range(0, 1) == 0)
          queue_load(pick_stray_node(), $urandom_range(0, 15), word_t'($urandom), 1'($urandom));
        else
          queue_load($urandom_range(0, NODES - 1), $urandom_range(12, 15),
                     word_t'($urandom), 1'($urandom));
      end else begin
        // vertex broken up by a load in the middle
        queue_neighbour(pick_graph_node(), pick_weight(), 1'b0, POS_TAME);
        queue_load($urandom_range(0, NODES - 1), $urandom_range(0, XFORM_WORDS - 1),
                   pick_xform_word($urandom_range(0, 3)), 1'b0);
        queue_neighbour(pick_graph_node(), pick_weight(), 1'b1, POS_TAME);
      end
    end
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(21, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word on the wire at a time, held until taken.
  // ---------------------------------------------------------------------------
  blend_word_t on_wire;
  int          send_gap;
  bit          tx_steady;
  int          words_total;
  int          words_taken;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        blend_apply(on_wire);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_wire = pending.pop_front();
          in_command       <= on_wire.cmd;
          in_node_index    <= on_wire.node;
          in_element_index <= on_wire.elem;
          in_element_value <= on_wire.value;
          in_blend_weight  <= on_wire.weight;
          in_last_neighbor <= on_wire.last;
          in_pos_x <= on_wire.px;
          in_pos_y <= on_wire.py;
          in_pos_z <= on_wire.pz;
          in_nrm_x <= on_wire.nx;
          in_nrm_y <= on_wire.ny;
          in_nrm_z <= on_wire.nz;
          in_valid <= 1'b1;
          // switch now and then between gappy and back-to-back stretches
          if ($urandom_range(0, 119) == 0) tx_steady = !tx_steady;
          send_gap <= pick_gap(tx_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every taken result checked against the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  int fails;
  int vertices_seen;
  int hold_left;
  bit rx_steady;

  function automatic void log_fail(string msg);
    if (fails < 10) $display("[%0t] %s", $time, msg);
    fails++;
  endfunction

  function automatic void check_vertex();
    moved_vertex_t due;
    word_t         got [6];
    word_t         want [6];
    string         tag [6];
    int            k;
    tag = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y", "nrm_z"};
    vertices_seen++;
    if (moved_due.size() == 0) begin
      log_fail($sformatf("vertex %0d arrived with nothing expected", vertices_seen));
      return;
    end
    due  = moved_due.pop_front();
    got  = '{out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z};
    want = '{due.px, due.py, due.pz, due.nx, due.ny, due.nz};
    for (k = 0; k < 6; k++)
      if (got[k] !== want[k])
        log_fail($sformatf("vertex %0d %s: expected %h, got %h",
                           vertices_seen, tag[k], want[k], got[k]));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_vertex();
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
        hold_left <= pick_gap(1'b0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 499) == 0) rx_steady = !rx_steady;
    end
  end

  // watchdog
  int unsigned cycle_count;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words taken, %0d results due",
               cycle_count, words_taken, words_total, moved_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build, reset, run, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < XFORM_WORDS; k++)
      blend_sum[k] = '0;
    build_stimulus();
    words_total = pending.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (words_taken < words_total) @(posedge clk);
    while (moved_due.size() != 0) @(posedge clk);
    // let the core settle so a stray extra result would still show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (moved_due.size() != 0)
      log_fail($sformatf("%0d results never arrived", moved_due.size()));
    $display("Run covered %0d transform loads and %0d neighbour words over %0d vertices;",
             loads_queued, neighbours_queued, vertices_queued);
    $display("%0d moved vertices checked, %0d field mismatches, %0d cycles.",
             vertices_seen, fails, cycle_count);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
